// File: sv/terrain_height_grid_query_defines.svh
// assertion macros for the terrain height grid query block
`ifndef TERRAIN_HEIGHT_GRID_QUERY_DEFINES_SVH
`define TERRAIN_HEIGHT_GRID_QUERY_DEFINES_SVH

// same-cycle implication
`define THGQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thgq same-cycle check failed");

// next-cycle implication
`define THGQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thgq next-cycle check failed");

`endif

// File: sv/thgq_pkg.sv
// shared types, widths and codes of the terrain height grid query block
`default_nettype none
package thgq_pkg;

    localparam int GRID_MAX   = 256;
    localparam int STORE_DIM  = 256;
    localparam int GRID_CAP   = (GRID_MAX < STORE_DIM) ? GRID_MAX : STORE_DIM;
    localparam int FRAC_BITS  = 8;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int HEIGHT_W   = 25;
    localparam int SPAN_W     = 24;
    localparam int COORD_W    = 32;
    localparam int CELL_W     = 8;
    localparam int ADDR_W     = 2 * CELL_W;
    localparam int U_W        = COORD_W + CELL_W;
    localparam int DIVD_W     = U_W + FRAC_BITS;
    localparam int PIX_SHIFT  = 23;
    localparam int DIFF_W     = HEIGHT_W + 1;
    localparam int PROD_W     = DIFF_W + WGT_W + 1;
    localparam int ACC_W      = PROD_W + 2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z     = 3'd1;
    localparam logic [2:0] REG_TERRAIN_SPAN = 3'd2;
    localparam logic [2:0] REG_GRID_POINTS  = 3'd3;
    localparam logic [2:0] REG_MAX_HEIGHT   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_WR,
        ST_OFFSET,
        ST_SCALE,
        ST_DIV_START,
        ST_DIV,
        ST_CHECK,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } thgq_state_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } thgq_interp_ctl_t;

endpackage
`default_nettype wire

// File: sv/thgq_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module thgq_div
    import thgq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DIVD_W-1:0]   dividend,
    input  wire logic [SPAN_W-1:0]   divisor,
    output logic                     busy,
    output logic                     done,
    output logic [DIVD_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SPAN_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [SPAN_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(DIVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? SPAN_W'(trial - {1'b0, divisor}) : trial[SPAN_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// File: sv/thgq_store.sv
// height store, one write port and one registered read port
`default_nettype none
module thgq_store
    import thgq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire logic [HEIGHT_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]   raddr,
    output logic [HEIGHT_W-1:0]      rdata
);

    logic [HEIGHT_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/thgq_interp.sv
// barycentric interpolation over one cell, multiply stage and sum stage
`default_nettype none
module thgq_interp
    import thgq_pkg::*;
(
    input  wire logic                    clk,
    input  wire thgq_interp_ctl_t        ctl,
    input  wire logic signed [HEIGHT_W-1:0] h00,
    input  wire logic signed [HEIGHT_W-1:0] h10,
    input  wire logic signed [HEIGHT_W-1:0] h01,
    input  wire logic signed [HEIGHT_W-1:0] h11,
    input  wire logic [FRAC_BITS-1:0]    fx,
    input  wire logic [FRAC_BITS-1:0]    fz,
    output logic signed [HEIGHT_W-1:0]   height
);

    logic                        lower;
    logic signed [HEIGHT_W-1:0]  base;
    logic signed [DIFF_W-1:0]    da;
    logic signed [DIFF_W-1:0]    db;
    logic [WGT_W-1:0]            wa;
    logic [WGT_W-1:0]            wb;
    logic signed [PROD_W-1:0]    pa;
    logic signed [PROD_W-1:0]    pb;
    logic signed [HEIGHT_W-1:0]  base_reg;
    logic signed [PROD_W-1:0]    pa_reg;
    logic signed [PROD_W-1:0]    pb_reg;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     rounded;
    logic signed [HEIGHT_W-1:0]  height_reg;

    assign lower = (({1'b0, fx} + {1'b0, fz}) <= WGT_W'(ONE));

    always_comb
    begin
        if (lower)
        begin
            base = h00;
            da   = DIFF_W'(h10) - DIFF_W'(h00);
            db   = DIFF_W'(h01) - DIFF_W'(h00);
            wa   = {1'b0, fx};
            wb   = {1'b0, fz};
        end
        else
        begin
            base = h11;
            da   = DIFF_W'(h10) - DIFF_W'(h11);
            db   = DIFF_W'(h01) - DIFF_W'(h11);
            wa   = WGT_W'(ONE) - {1'b0, fz};
            wb   = WGT_W'(ONE) - {1'b0, fx};
        end
    end

    assign pa = PROD_W'(da) * PROD_W'($signed({1'b0, wa}));
    assign pb = PROD_W'(db) * PROD_W'($signed({1'b0, wb}));

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            base_reg <= base;
            pa_reg   <= pa;
            pb_reg   <= pb;
        end
    end

    assign acc = {{(ACC_W-HEIGHT_W-FRAC_BITS){base_reg[HEIGHT_W-1]}}, base_reg, FRAC_BITS'(0)}
               + ACC_W'(pa_reg) + ACC_W'(pb_reg);
    assign rounded = acc + ACC_W'(ONE / 2);

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            height_reg <= rounded[FRAC_BITS+HEIGHT_W-1:FRAC_BITS];
        end
    end

    assign height = height_reg;

endmodule
`default_nettype wire

// File: sv/terrain_height_grid_query.sv
// terrain height grid query: heightmap load and barycentric height lookup
//
// usage: an input transfer with mode 0 decodes pixel_rgb to a height and writes
// it to the grid store at (grid_column, grid_row); it gives no result. a
// transfer with mode 1 looks up the height at (world_x, world_z) and gives one
// result transfer carrying height and outside.
// one item at a time: in_ready is high only while the block is idle.
// a load passes through a multiply state and a write state before the next in_ready.
// a query steps through offset, scale, divider start, the bit-serial dividers
// until their done flag, range check, store reads on the single read port,
// the interpolation multiply and sum, and output load; an outside query skips
// the store reads and the interpolation.
// the result waits in an output register, so a new item is taken while
// out_ready is low; a finished query stalls only while that register is full.
// reset clears the control state and loads the register defaults; the grid
// store holds nothing defined until written by loads.
// the user writes configuration through the apb port only while the block is idle; the block does not enforce this.
`default_nettype none
`include "terrain_height_grid_query_defines.svh"
module terrain_height_grid_query
    import thgq_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [4:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [7:0]                  grid_column,
    input  wire logic [7:0]                  grid_row,
    input  wire logic [23:0]                 pixel_rgb,
    input  wire logic signed [31:0]          world_x,
    input  wire logic signed [31:0]          world_z,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [24:0]               height,
    output logic                             outside
);

    thgq_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_z_reg;
    logic [SPAN_W-1:0]         terrain_span_reg;
    logic [8:0]                grid_points_reg;
    logic [SPAN_W-1:0]         max_height_reg;

    logic                      mode_reg;
    logic [CELL_W-1:0]         col_reg;
    logic [CELL_W-1:0]         row_reg;
    logic [23:0]               pix_reg;
    logic signed [COORD_W-1:0] wx_reg;
    logic signed [COORD_W-1:0] wz_reg;

    logic signed [49:0]        load_prod_reg;
    logic signed [COORD_W:0]   tx_reg;
    logic signed [COORD_W:0]   tz_reg;
    logic [U_W-1:0]            ux_reg;
    logic [U_W-1:0]            uz_reg;
    logic                      neg_reg;
    logic                      outside_q_reg;
    logic [CELL_W-1:0]         cx_reg;
    logic [CELL_W-1:0]         cz_reg;
    logic [FRAC_BITS-1:0]      fx_reg;
    logic [FRAC_BITS-1:0]      fz_reg;
    logic [2:0]                rd_cnt_reg;
    logic [HEIGHT_W-1:0]       h_reg [0:3];

    logic                      out_valid_reg;
    logic signed [HEIGHT_W-1:0] height_reg;
    logic                      outside_reg;

    logic                      cfg_we;
    logic [2:0]                cfg_idx;
    logic [8:0]                grid_n;
    logic [CELL_W-1:0]         nm1;
    logic [SPAN_W-1:0]         span_eff;
    logic                      div_start;
    logic                      div_busy_x;
    logic                      div_busy_z;
    logic                      div_done_x;
    logic                      div_done_z;
    logic [DIVD_W-1:0]         qx;
    logic [DIVD_W-1:0]         qz;
    logic                      cell_out;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [HEIGHT_W-1:0]       mem_rdata;
    logic [CELL_W-1:0]         rd_x;
    logic [CELL_W-1:0]         rd_z;
    logic                      out_load;
    logic signed [HEIGHT_W-1:0] interp_height;
    thgq_interp_ctl_t          interp_ctl;
    logic signed [24:0]        raw;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_z_reg     <= '0;
            terrain_span_reg <= SPAN_W'(204800);
            grid_points_reg  <= 9'd256;
            max_height_reg   <= SPAN_W'(10240);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ORIGIN_X:     origin_x_reg     <= pwdata;
                REG_ORIGIN_Z:     origin_z_reg     <= pwdata;
                REG_TERRAIN_SPAN: terrain_span_reg <= pwdata[SPAN_W-1:0];
                REG_GRID_POINTS:  grid_points_reg  <= pwdata[8:0];
                REG_MAX_HEIGHT:   max_height_reg   <= pwdata[SPAN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ORIGIN_X:     prdata = origin_x_reg;
            REG_ORIGIN_Z:     prdata = origin_z_reg;
            REG_TERRAIN_SPAN: prdata = 32'(terrain_span_reg);
            REG_GRID_POINTS:  prdata = 32'(grid_points_reg);
            REG_MAX_HEIGHT:   prdata = 32'(max_height_reg);
            default:          prdata = '0;
        endcase
    end

    // grid size and span used by queries
    always_comb
    begin
        if (grid_points_reg < 9'd2)
        begin
            grid_n = 9'd2;
        end
        else if (grid_points_reg > 9'(GRID_CAP))
        begin
            grid_n = 9'(GRID_CAP);
        end
        else
        begin
            grid_n = grid_points_reg;
        end
    end

    assign nm1      = CELL_W'(grid_n - 9'd1);
    assign span_eff = (terrain_span_reg == '0) ? SPAN_W'(1) : terrain_span_reg;
    assign cell_out = neg_reg
                   || (qx[DIVD_W-1:FRAC_BITS] >= U_W'(nm1))
                   || (qz[DIVD_W-1:FRAC_BITS] >= U_W'(nm1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (mode == MODE_LOAD) ? ST_LOAD_MUL : ST_OFFSET;
                end
            end
            ST_LOAD_MUL:  state_next = ST_LOAD_WR;
            ST_LOAD_WR:   state_next = ST_IDLE;
            ST_OFFSET:    state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done_x)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:     state_next = cell_out ? ST_OUT : ST_READ;
            ST_READ:
            begin
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:       state_next = ST_SUM;
            ST_SUM:       state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready          = 1'b0;
        div_start         = 1'b0;
        mem_we            = 1'b0;
        interp_ctl.mul_en = 1'b0;
        interp_ctl.sum_en = 1'b0;
        out_load          = 1'b0;
        case (state_reg)
            ST_IDLE:      in_ready = 1'b1;
            ST_LOAD_WR:   mem_we = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_MUL:       interp_ctl.mul_en = 1'b1;
            ST_SUM:       interp_ctl.sum_en = 1'b1;
            ST_OUT:       out_load = !out_valid_reg || out_ready;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            end
            else
            begin
                rd_cnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    assign raw = $signed({1'b0, pix_reg}) - 25'sd8388608;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            col_reg  <= grid_column;
            row_reg  <= grid_row;
            pix_reg  <= pixel_rgb;
            wx_reg   <= world_x;
            wz_reg   <= world_z;
        end
        if (state_reg == ST_LOAD_MUL)
        begin
            load_prod_reg <= 50'(raw) * 50'($signed({1'b0, max_height_reg}));
        end
        if (state_reg == ST_OFFSET)
        begin
            tx_reg <= (COORD_W+1)'(wx_reg) - (COORD_W+1)'(origin_x_reg);
            tz_reg <= (COORD_W+1)'(wz_reg) - (COORD_W+1)'(origin_z_reg);
        end
        if (state_reg == ST_SCALE)
        begin
            neg_reg <= tx_reg[COORD_W] || tz_reg[COORD_W];
            ux_reg  <= U_W'(tx_reg[COORD_W-1:0]) * U_W'(nm1);
            uz_reg  <= U_W'(tz_reg[COORD_W-1:0]) * U_W'(nm1);
        end
        if (state_reg == ST_CHECK)
        begin
            outside_q_reg <= cell_out;
            cx_reg        <= qx[FRAC_BITS+CELL_W-1:FRAC_BITS];
            cz_reg        <= qz[FRAC_BITS+CELL_W-1:FRAC_BITS];
            fx_reg        <= qx[FRAC_BITS-1:0];
            fz_reg        <= qz[FRAC_BITS-1:0];
        end
        if ((state_reg == ST_READ) && (rd_cnt_reg != 3'd0))
        begin
            h_reg[2'(rd_cnt_reg - 3'd1)] <= mem_rdata;
        end
        if (out_load)
        begin
            height_reg  <= outside_q_reg ? '0 : interp_height;
            outside_reg <= outside_q_reg;
        end
    end

    // read order: h00, h10, h01, h11
    assign rd_x      = cx_reg + CELL_W'(rd_cnt_reg[0]);
    assign rd_z      = cz_reg + CELL_W'(rd_cnt_reg[1]);
    assign mem_raddr = {rd_x, rd_z};

    thgq_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({ux_reg, FRAC_BITS'(0)}),
        .divisor  (span_eff),
        .busy     (div_busy_x),
        .done     (div_done_x),
        .quotient (qx)
    );

    thgq_div u_div_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({uz_reg, FRAC_BITS'(0)}),
        .divisor  (span_eff),
        .busy     (div_busy_z),
        .done     (div_done_z),
        .quotient (qz)
    );

    thgq_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({col_reg, row_reg}),
        .wdata (load_prod_reg[PIX_SHIFT+HEIGHT_W-1:PIX_SHIFT]),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    thgq_interp u_interp (
        .clk    (clk),
        .ctl    (interp_ctl),
        .h00    (h_reg[0]),
        .h10    (h_reg[1]),
        .h01    (h_reg[2]),
        .h11    (h_reg[3]),
        .fx     (fx_reg),
        .fz     (fz_reg),
        .height (interp_height)
    );

    assign out_valid = out_valid_reg;
    assign height    = height_reg;
    assign outside   = outside_reg;

    `THGQ_ASSERT_IMP(a_outside_zero, out_valid && outside, height == '0)
    `THGQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `THGQ_ASSERT_IMP(a_div_idle, in_ready, !div_busy_x && !div_busy_z)
    `THGQ_ASSERT_IMP(a_div_lockstep, div_done_x, div_done_z)
    `THGQ_ASSERT_IMP(a_write_load_only, mem_we, mode_reg == MODE_LOAD)

endmodule
`default_nettype wire
